@@ src/ipm_pkg.sv @@
// ipm_pkg: shared widths, constants, command/status structs and the
// bit-serial divide step for the i/q block power meter.
// no dependencies.
`timescale 1ns / 1ps

package ipm_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int MAX_BLOCK_SAMPLES = 16384;
    localparam int CNT_W             = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int REM_W             = $clog2(MAX_BLOCK_SAMPLES);
    localparam int SUM_W             = 31;
    localparam int PSUM_W            = 46;
    localparam int SQ_W              = 33;
    localparam int MAG_W             = 15;
    localparam int DC_W              = 24;
    localparam int DCDIV_W           = SUM_W + 8;
    localparam int DCDIV_IDX_W       = 6;
    localparam int PWR_SHIFT         = 30;
    localparam int PWR_IDX_W         = 6;
    localparam int DIV_STEPS         = PSUM_W + PWR_SHIFT;
    localparam int DIV_CNT_W         = 7;
    localparam int LOG_OFS           = 22 + PWR_SHIFT;
    localparam int FRAC_W            = 16;
    localparam int FCNT_W            = 5;
    localparam int EXP_W             = 7;
    localparam int L_W               = EXP_W + FRAC_W;
    localparam int PROD_W            = 31;
    localparam int Y_W               = PROD_W - 8;
    localparam int T_W               = Y_W - 1;
    localparam int RECIP_W           = 46;
    localparam int RECIP_SH          = 30;
    localparam int PWR_W             = 16;
    localparam int LOG_MUL           = 301;
    localparam int RECIP_MUL         = 10737419;
    localparam int DIV100_BIAS       = 99;
    localparam int ZERO_DBFS_Q8      = -30720;

    typedef struct packed {
        logic acc_en;
        logic load;
        logic div_step;
        logic log1;
        logic log2;
        logic log3;
    } ipm_cmd_t;

    typedef struct packed {
        logic block_end;
        logic div_done;
    } ipm_sts_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             qbit;
    } ipm_div_t;

    // one restoring step: bring in a dividend bit, subtract the count if it fits
    function automatic ipm_div_t ipm_div_step(input logic [REM_W-1:0] rem,
                                              input logic             din,
                                              input logic [CNT_W-1:0] den);
        logic [CNT_W-1:0] r2;
        ipm_div_t         res;
        r2 = {rem, din};
        if (r2 >= den)
        begin
            res.qbit = 1'b1;
            res.rem  = REM_W'(r2 - den);
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = REM_W'(r2);
        end
        return res;
    endfunction

endpackage

@@ src/ipm_ctrl.sv @@
// ipm_ctrl: sequencer for sample accumulation, end-of-block division,
// log scaling and the output register valid. uses ipm_pkg.
`timescale 1ns / 1ps

module ipm_ctrl
    import ipm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  ipm_sts_t sts,
    output ipm_cmd_t cmd
);

    localparam logic [2:0] ST_ACC  = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_LOG1 = 3'd3;
    localparam logic [2:0] ST_LOG2 = 3'd4;
    localparam logic [2:0] ST_LOG3 = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_xfer;
    logic       out_free;

    assign in_ready  = (state_reg == ST_ACC);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.acc_en   = in_xfer;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_xfer && sts.block_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_LOG1;
                end
            end
            ST_LOG1:
            begin
                cmd.log1   = 1'b1;
                state_next = ST_LOG2;
            end
            ST_LOG2:
            begin
                cmd.log2   = 1'b1;
                state_next = ST_LOG3;
            end
            ST_LOG3:
            begin
                if (out_free)
                begin
                    cmd.log3   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.log3)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_end_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && sts.block_end) |=> (state_reg == ST_LOAD))
        else $error("block end did not start the load");
    a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV))
        else $error("load not followed by division");
    a_log3_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.log3 |=> (out_valid_reg && state_reg == ST_ACC))
        else $error("result not presented after finish");
`endif

endmodule

@@ src/ipm_datapath.sv @@
// ipm_datapath: accumulators, three bit-serial dividers by the sample count,
// log2 scaling to dbfs and the result registers. uses ipm_pkg.
`timescale 1ns / 1ps

module ipm_datapath
    import ipm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] q_sample,
    input  logic                       last_sample,
    input  ipm_cmd_t                   cmd,
    output ipm_sts_t                   sts,
    output logic signed [PWR_W-1:0]    power_dbfs_q8,
    output logic signed [DC_W-1:0]     dc_i_q8,
    output logic signed [DC_W-1:0]     dc_q_q8,
    output logic [MAG_W-1:0]           peak_i,
    output logic [MAG_W-1:0]           peak_q,
    output logic [CNT_W-1:0]           block_count
);

    // accumulators
    logic signed [SUM_W-1:0] sum_i_reg;
    logic signed [SUM_W-1:0] sum_q_reg;
    logic [PSUM_W-1:0]       sum_p_reg;
    logic [MAG_W-1:0]        max_i_reg;
    logic [MAG_W-1:0]        max_q_reg;
    logic [CNT_W-1:0]        cnt_reg;

    // division operands and state
    logic [SUM_W-1:0]        mag_i_reg;
    logic [SUM_W-1:0]        mag_q_reg;
    logic                    neg_i_reg;
    logic                    neg_q_reg;
    logic [PSUM_W-1:0]       pwr_reg;
    logic                    pzero_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [MAG_W-1:0]        pk_i_reg;
    logic [MAG_W-1:0]        pk_q_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [REM_W-1:0]        rem_i_reg;
    logic [REM_W-1:0]        rem_q_reg;
    logic [REM_W-1:0]        rem_p_reg;
    logic [DC_W-1:0]         quo_i_reg;
    logic [DC_W-1:0]         quo_q_reg;
    logic                    found_reg;
    logic [DIV_CNT_W-1:0]    lead_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [FCNT_W-1:0]       fcnt_reg;

    // log pipeline
    logic signed [PROD_W-1:0] prod_reg;
    logic [RECIP_W-1:0]       recip_reg;
    logic                     yneg_reg;

    // result registers
    logic signed [PWR_W-1:0] pwr_out_reg;
    logic signed [DC_W-1:0]  dc_i_out_reg;
    logic signed [DC_W-1:0]  dc_q_out_reg;
    logic [MAG_W-1:0]        pk_i_out_reg;
    logic [MAG_W-1:0]        pk_q_out_reg;
    logic [CNT_W-1:0]        cnt_out_reg;

    logic signed [2*SAMPLE_W-1:0] sq_i;
    logic signed [2*SAMPLE_W-1:0] sq_q;
    logic [SQ_W-1:0]              sq_sum;
    logic [SAMPLE_W-1:0]          abs_i;
    logic [SAMPLE_W-1:0]          abs_q;
    logic [MAG_W-1:0]             sat_i;
    logic [MAG_W-1:0]             sat_q;
    logic [CNT_W-1:0]             cnt_inc;
    logic [DCDIV_W-1:0]           dvd_i;
    logic [DCDIV_W-1:0]           dvd_q;
    logic [PWR_IDX_W-1:0]         pidx;
    logic                         bit_i;
    logic                         bit_q;
    logic                         bit_p;
    ipm_div_t                     st_i;
    ipm_div_t                     st_q;
    ipm_div_t                     st_p;
    logic signed [EXP_W-1:0]      expo;
    logic signed [L_W-1:0]        l_val;
    logic signed [Y_W-1:0]        y_val;
    logic signed [Y_W-1:0]        y_mag;
    logic [PWR_W-1:0]             q100;

    // per-sample terms
    always_comb
    begin
        sq_i    = i_sample * i_sample;
        sq_q    = q_sample * q_sample;
        sq_sum  = SQ_W'(unsigned'(sq_i)) + SQ_W'(unsigned'(sq_q));
        abs_i   = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : unsigned'(i_sample);
        abs_q   = q_sample[SAMPLE_W-1] ? SAMPLE_W'(-q_sample) : unsigned'(q_sample);
        sat_i   = abs_i[SAMPLE_W-1] ? {MAG_W{1'b1}} : abs_i[MAG_W-1:0];
        sat_q   = abs_q[SAMPLE_W-1] ? {MAG_W{1'b1}} : abs_q[MAG_W-1:0];
        cnt_inc = cnt_reg + CNT_W'(1);
    end

    assign sts.block_end = last_sample || (cnt_inc == CNT_W'(MAX_BLOCK_SAMPLES));
    assign sts.div_done  = (div_cnt_reg == '0);

    // dividend bits, msb first
    always_comb
    begin
        dvd_i = {mag_i_reg, 8'd0};
        dvd_q = {mag_q_reg, 8'd0};
        pidx  = PWR_IDX_W'(div_cnt_reg - DIV_CNT_W'(PWR_SHIFT));
        bit_i = (div_cnt_reg < DIV_CNT_W'(DCDIV_W)) ? dvd_i[div_cnt_reg[DCDIV_IDX_W-1:0]] : 1'b0;
        bit_q = (div_cnt_reg < DIV_CNT_W'(DCDIV_W)) ? dvd_q[div_cnt_reg[DCDIV_IDX_W-1:0]] : 1'b0;
        bit_p = (div_cnt_reg >= DIV_CNT_W'(PWR_SHIFT)) ? pwr_reg[pidx] : 1'b0;
        st_i  = ipm_div_step(rem_i_reg, bit_i, n_reg);
        st_q  = ipm_div_step(rem_q_reg, bit_q, n_reg);
        st_p  = ipm_div_step(rem_p_reg, bit_p, n_reg);
    end

    // log2 in q16 and the divide by 25600 done as shift plus reciprocal
    always_comb
    begin
        expo  = EXP_W'($signed({1'b0, lead_reg}) - LOG_OFS);
        l_val = {expo, frac_reg};
        y_val = Y_W'(prod_reg >>> 8);
        y_mag = y_val[Y_W-1] ? Y_W'(-y_val + Y_W'(DIV100_BIAS)) : y_val;
        q100  = recip_reg[RECIP_SH +: PWR_W];
    end

    // sample accumulation and block load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
            sum_p_reg <= '0;
            max_i_reg <= '0;
            max_q_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.load)
        begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
            sum_p_reg <= '0;
            max_i_reg <= '0;
            max_q_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.acc_en)
        begin
            sum_i_reg <= sum_i_reg + SUM_W'(i_sample);
            sum_q_reg <= sum_q_reg + SUM_W'(q_sample);
            sum_p_reg <= sum_p_reg + PSUM_W'(sq_sum);
            if (sat_i > max_i_reg)
            begin
                max_i_reg <= sat_i;
            end
            if (sat_q > max_q_reg)
            begin
                max_q_reg <= sat_q;
            end
            cnt_reg <= cnt_inc;
        end
    end

    // divider operands and iteration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_i_reg   <= sum_i_reg[SUM_W-1];
            neg_q_reg   <= sum_q_reg[SUM_W-1];
            mag_i_reg   <= sum_i_reg[SUM_W-1] ? SUM_W'(-sum_i_reg) : unsigned'(sum_i_reg);
            mag_q_reg   <= sum_q_reg[SUM_W-1] ? SUM_W'(-sum_q_reg) : unsigned'(sum_q_reg);
            pwr_reg     <= sum_p_reg;
            pzero_reg   <= (sum_p_reg == '0);
            n_reg       <= cnt_reg;
            pk_i_reg    <= max_i_reg;
            pk_q_reg    <= max_q_reg;
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
            rem_i_reg   <= '0;
            rem_q_reg   <= '0;
            rem_p_reg   <= '0;
            quo_i_reg   <= '0;
            quo_q_reg   <= '0;
            found_reg   <= 1'b0;
            lead_reg    <= '0;
            frac_reg    <= '0;
            fcnt_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            rem_i_reg   <= st_i.rem;
            rem_q_reg   <= st_q.rem;
            rem_p_reg   <= st_p.rem;
            quo_i_reg   <= {quo_i_reg[DC_W-2:0], st_i.qbit};
            quo_q_reg   <= {quo_q_reg[DC_W-2:0], st_q.qbit};
            // leading one gives the exponent, the next bits the mantissa
            if (!found_reg && st_p.qbit)
            begin
                found_reg <= 1'b1;
                lead_reg  <= div_cnt_reg;
            end
            else if (found_reg && (fcnt_reg < FCNT_W'(FRAC_W)))
            begin
                frac_reg <= {frac_reg[FRAC_W-2:0], st_p.qbit};
                fcnt_reg <= fcnt_reg + FCNT_W'(1);
            end
        end
    end

    // log scaling stages
    always_ff @(posedge clk)
    begin
        if (cmd.log1)
        begin
            prod_reg <= PROD_W'(l_val) * PROD_W'(LOG_MUL);
        end
        if (cmd.log2)
        begin
            recip_reg <= RECIP_W'(unsigned'(y_mag[T_W-1:0])) * RECIP_W'(RECIP_MUL);
            yneg_reg  <= y_val[Y_W-1];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.log3)
        begin
            if (pzero_reg)
            begin
                pwr_out_reg <= PWR_W'(ZERO_DBFS_Q8);
            end
            else
            begin
                pwr_out_reg <= yneg_reg ? PWR_W'(-q100) : q100;
            end
            dc_i_out_reg <= neg_i_reg ? DC_W'(-quo_i_reg) : quo_i_reg;
            dc_q_out_reg <= neg_q_reg ? DC_W'(-quo_q_reg) : quo_q_reg;
            pk_i_out_reg <= pk_i_reg;
            pk_q_out_reg <= pk_q_reg;
            cnt_out_reg  <= n_reg;
        end
    end

    assign power_dbfs_q8 = pwr_out_reg;
    assign dc_i_q8       = dc_i_out_reg;
    assign dc_q_q8       = dc_q_out_reg;
    assign peak_i        = pk_i_out_reg;
    assign peak_q        = pk_q_out_reg;
    assign block_count   = cnt_out_reg;

endmodule

@@ src/iq_block_power_dc_peak_meter.sv @@
// iq_block_power_dc_peak_meter: top level joining the sequencer and the
// datapath. uses ipm_pkg, ipm_ctrl, ipm_datapath.
`timescale 1ns / 1ps

// Measures one capture block of signed 16-bit i/q pairs: dc means in q8,
// peak magnitudes, sample count and mean power in dbfs (q8, -120 dbfs for
// zero power). Within a block a sample is taken every cycle. A block ends on
// last_sample or at 16384 samples; the block then has its result worked out
// (a load step, the bit-serial dividers by the sample count, then log
// scaling), plus any wait for the previous result to be taken, and in_ready
// is low throughout. The result sits in an output register, so a new block
// starts while it waits.
module iq_block_power_dc_peak_meter
    import ipm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] q_sample,
    input  logic                       last_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PWR_W-1:0]    power_dbfs_q8,
    output logic signed [DC_W-1:0]     dc_i_q8,
    output logic signed [DC_W-1:0]     dc_q_q8,
    output logic [MAG_W-1:0]           peak_i,
    output logic [MAG_W-1:0]           peak_q,
    output logic [CNT_W-1:0]           block_count
);

    ipm_cmd_t cmd;
    ipm_sts_t sts;

    // sequencer
    ipm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic
    ipm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .i_sample      (i_sample),
        .q_sample      (q_sample),
        .last_sample   (last_sample),
        .cmd           (cmd),
        .sts           (sts),
        .power_dbfs_q8 (power_dbfs_q8),
        .dc_i_q8       (dc_i_q8),
        .dc_q_q8       (dc_q_q8),
        .peak_i        (peak_i),
        .peak_q        (peak_q),
        .block_count   (block_count)
    );

endmodule

@@ tb/sv/power_meter_scoreboard.sv @@
// power_meter_scoreboard: watches both channels of the i/q block power meter,
// predicts each block result and compares it field by field.
// depends on ipm_pkg for the port widths.
`timescale 1ns / 1ps

module power_meter_scoreboard
    import ipm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] q_sample,
    input  logic                       last_sample,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [PWR_W-1:0]    power_dbfs_q8,
    input  logic signed [DC_W-1:0]     dc_i_q8,
    input  logic signed [DC_W-1:0]     dc_q_q8,
    input  logic [MAG_W-1:0]           peak_i,
    input  logic [MAG_W-1:0]           peak_q,
    input  logic [CNT_W-1:0]           block_count,
    output int                         fail_count,
    output int                         pending_blocks,
    output int                         blocks_checked
);

    typedef struct packed {
        logic signed [PWR_W-1:0] pwr;
        logic signed [DC_W-1:0]  dci;
        logic signed [DC_W-1:0]  dcq;
        logic [MAG_W-1:0]        pki;
        logic [MAG_W-1:0]        pkq;
        logic [CNT_W-1:0]        cnt;
    } block_stats_t;

    block_stats_t stats_q[$];

    // running block state
    longint sum_i;
    longint sum_q;
    longint sum_pwr;
    int     max_i;
    int     max_q;
    int     seen;

    // mean power in dbfs, q8, floor of the piecewise-linear log2 times 3.01
    function automatic logic signed [PWR_W-1:0] dbfs_q8(longint s, int n);
        longint num;
        longint den;
        longint ex;
        longint frac;
        longint prod;
        num = s;
        den = longint'(n) << 22;
        ex  = 0;
        if (s == 0)
        begin
            return PWR_W'(ZERO_DBFS_Q8);
        end
        while (num < den)
        begin
            num = num << 1;
            ex--;
        end
        while (num >= (den << 1))
        begin
            den = den << 1;
            ex++;
        end
        frac = ((num - den) << 16) / den;
        prod = (ex * 65536 + frac) * LOG_MUL;
        if (prod >= 0)
            return PWR_W'(prod / 25600);
        return PWR_W'(-((-prod + 25599) / 25600));
    endfunction

    function automatic int sat_mag(logic signed [SAMPLE_W-1:0] x);
        int v;
        v = x;
        if (v < 0)
            v = -v;
        return (v > 32767) ? 32767 : v;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    assign pending_blocks = stats_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        block_stats_t want;
        int           ai;
        int           aq;
        if (!rst_n)
        begin
            sum_i = 0; sum_q = 0; sum_pwr = 0;
            max_i = 0; max_q = 0; seen = 0;
            fail_count     = 0;
            blocks_checked = 0;
            stats_q.delete();
        end
        else
        begin
            // accumulate an accepted sample, close the block on last or at the cap
            if (in_valid && in_ready)
            begin
                ai = sat_mag(i_sample);
                aq = sat_mag(q_sample);
                sum_i   += i_sample;
                sum_q   += q_sample;
                sum_pwr += longint'(i_sample) * i_sample + longint'(q_sample) * q_sample;
                if (ai > max_i) max_i = ai;
                if (aq > max_q) max_q = aq;
                seen++;
                if (last_sample || seen >= MAX_BLOCK_SAMPLES)
                begin
                    want.pwr = dbfs_q8(sum_pwr, seen);
                    want.dci = DC_W'((sum_i * 256) / seen);
                    want.dcq = DC_W'((sum_q * 256) / seen);
                    want.pki = MAG_W'(max_i);
                    want.pkq = MAG_W'(max_q);
                    want.cnt = CNT_W'(seen);
                    stats_q.push_back(want);
                    sum_i = 0; sum_q = 0; sum_pwr = 0;
                    max_i = 0; max_q = 0; seen = 0;
                end
            end
            // compare a result transfer with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                begin
                    $display("[%0t] mismatch: result with no block pending", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = stats_q.pop_front();
                    blocks_checked++;
                    if (power_dbfs_q8 !== want.pwr) report("power_dbfs_q8", power_dbfs_q8, want.pwr);
                    if (dc_i_q8 !== want.dci)       report("dc_i_q8", dc_i_q8, want.dci);
                    if (dc_q_q8 !== want.dcq)       report("dc_q_q8", dc_q_q8, want.dcq);
                    if (peak_i !== want.pki)        report("peak_i", peak_i, want.pki);
                    if (peak_q !== want.pkq)        report("peak_q", peak_q, want.pkq);
                    if (block_count !== want.cnt)   report("block_count", block_count, want.cnt);
                end
            end
        end
    end

endmodule

@@ tb/sv/tb_iq_block_power_dc_peak_meter.sv @@
// tb_iq_block_power_dc_peak_meter: drives i/q capture blocks into the meter,
// throttles the result side and gives the verdict.
// depends on ipm_pkg, the meter rtl and power_meter_scoreboard.
`timescale 1ns / 1ps

module tb_iq_block_power_dc_peak_meter;
    import ipm_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic signed [SAMPLE_W-1:0] q_sample;
    logic                       last_sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [PWR_W-1:0]    power_dbfs_q8;
    logic signed [DC_W-1:0]     dc_i_q8;
    logic signed [DC_W-1:0]     dc_q_q8;
    logic [MAG_W-1:0]           peak_i;
    logic [MAG_W-1:0]           peak_q;
    logic [CNT_W-1:0]           block_count;

    int fail_count;
    int pending_blocks;
    int blocks_checked;
    int samples_sent;
    bit calm;          // no idling on either side
    bit squeeze_req;   // ask the receiver for one long hold-off
    int hold_cycles;

    iq_block_power_dc_peak_meter DUT (.*);

    power_meter_scoreboard checker_i (.*);

    // clock
    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // fixed time limit
    initial
    begin
        #80_000_000;
        $display("FAIL iq_block_power_dc_peak_meter");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        bit squeezed;
        out_ready   = 1'b0;
        hold_cycles = 0;
        squeezed    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req && !squeezed)
            begin
                hold_cycles = 600;
                squeezed    = 1'b1;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // send one sample, idling at random first
    task automatic send(logic signed [SAMPLE_W-1:0] iv, logic signed [SAMPLE_W-1:0] qv,
                        logic lst);
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        i_sample    <= iv;
        q_sample    <= qv;
        last_sample <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($signed($urandom_range(128)) - 64);
            2:
            begin
                case ($urandom_range(4))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return SAMPLE_W'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    // one block of random content
    task automatic send_block(int len);
        for (int k = 1; k <= len; k++)
            send(pick_sample(), pick_sample(), k == len);
    endtask

    initial
    begin
        int len;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        i_sample     = '0;
        q_sample     = '0;
        last_sample  = 1'b0;
        calm         = 1'b0;
        squeeze_req  = 1'b0;
        samples_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero power, full-scale extremes, saturating magnitude, dc sign
        send(16'sd0, 16'sd0, 1'b1);
        send(-16'sd32768, -16'sd32768, 1'b1);
        send(16'sd32767, 16'sd32767, 1'b1);
        send(-16'sd32768, 16'sd32767, 1'b0);
        send(16'sd32767, -16'sd32768, 1'b1);
        send(-16'sd1, 16'sd1, 1'b0);
        send(16'sd0, 16'sd0, 1'b0);
        send(16'sd0, 16'sd0, 1'b1);
        send(16'sd1, -16'sd1, 1'b1);
        send(16'sd2048, 16'sd0, 1'b1);
        send(-16'sd2048, 16'sd0, 1'b1);
        send(16'sd1448, 16'sd1448, 1'b1);
        send(-16'sd7, 16'sd5, 1'b0);
        send(16'sd3, -16'sd2, 1'b0);
        send(16'sd0, 16'sd0, 1'b1);

        // block that hits the sample cap without a last marker
        calm = 1'b1;
        for (int k = 0; k < MAX_BLOCK_SAMPLES; k++)
            send(pick_sample(), pick_sample(), 1'b0);
        send_block(3);
        calm = 1'b0;

        // receiver holds off while short blocks keep coming
        squeeze_req = 1'b1;
        for (int b = 0; b < 20; b++)
            send_block($urandom_range(1, 3));
        squeeze_req = 1'b0;

        // random blocks, mostly short, with a stretch of no idling
        while (samples_sent < MAX_BLOCK_SAMPLES + 2100)
        begin
            calm = (samples_sent > MAX_BLOCK_SAMPLES + 900)
                && (samples_sent < MAX_BLOCK_SAMPLES + 1300);
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            send_block(len);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (pending_blocks != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("sent %0d samples, checked %0d block results", samples_sent, blocks_checked);
        $display("covered zero power, full scale, saturation, the sample cap and output stalls");
        if (fail_count == 0)
            $display("PASS iq_block_power_dc_peak_meter");
        else
            $display("FAIL iq_block_power_dc_peak_meter");
        $finish;
    end

endmodule
